@@ hw/rtl/grcc_pkg.sv @@
`default_nettype none
package grcc_pkg;
  localparam int unsigned MaxVertices = 64;

  typedef enum logic [1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_RUN      = 2'd2,
    OP_NONE     = 2'd3
  } opcode_e;

  // Adjacency-row bus: walker issues a row read, the store answers in the next cycle.
  typedef struct packed {
    logic req;
    logic clear;
    logic wr;
  } adj_ctrl_t;
endpackage
`default_nettype wire

@@ hw/rtl/graph_root_cover_counter.sv @@
`default_nettype none
// Channel   Direction  Handshake            Payload
// request   in         in_valid_i/in_stall_o opcode_i, from_vertex_i, to_vertex_i
// result    out        out_valid_o/out_stall_i root_count_o
// config    in         cfg_we_i             cfg_wdata_i (vertex_count)
//
// Add edge is a row read-modify-write and holds off the next request while it writes;
// clear and no-op do not. In a run each stack push or pop passes through stack read,
// row read and the shared row search; the outer scan steps one vertex at a time;
// each finish-order entry is read, awaited and tested.
// Reset clears the graph via row valid bits at once; no clearing pass.
// A stalled result holds in its output register; no new request until taken.
module graph_root_cover_counter #(
  parameter int unsigned MaxVertices = grcc_pkg::MaxVertices
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [1:0]                     opcode_i,
  input  wire logic [5:0]                     from_vertex_i,
  input  wire logic [5:0]                     to_vertex_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [6:0]                          root_count_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [6:0]                     cfg_wdata_i
);
  import grcc_pkg::*;
  localparam int unsigned Aw = $clog2(MaxVertices);

  logic [6:0]   vcount_q;
  logic [Aw:0]  n_eff;
  logic         running_q;
  logic         accept;
  logic         adj_busy;
  adj_ctrl_t    adj;
  logic         walk_done;
  logic [Aw:0]  roots;
  logic         rd;
  logic [Aw-1:0] rd_row;
  logic [MaxVertices-1:0] row;
  logic         in_range;

  assign n_eff = ({25'd0, vcount_q} > 32'(MaxVertices)) ? (Aw+1)'(MaxVertices)
                                                         : (Aw+1)'(vcount_q);
  assign in_stall_o = running_q || out_valid_o || adj_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(from_vertex_i) < MaxVertices) && (32'(to_vertex_i) < MaxVertices);
  assign adj.wr     = accept && (opcode_i == OP_ADD_EDGE) && in_range;
  assign adj.clear  = accept && (opcode_i == OP_CLEAR);
  assign adj.req    = rd;

  grcc_adj #(.MaxVertices(MaxVertices)) u_adj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (adj.clear),
    .set_i     (adj.wr),
    .set_row_i (Aw'(from_vertex_i)),
    .set_col_i (Aw'(to_vertex_i)),
    .rd_i      (adj.req),
    .rd_row_i  (rd_row),
    .row_o     (row),
    .busy_o    (adj_busy)
  );

  grcc_walk #(.MaxVertices(MaxVertices)) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept && (opcode_i == OP_RUN)),
    .n_i      (n_eff),
    .rd_o     (rd),
    .rd_row_o (rd_row),
    .row_i    (row),
    .done_o   (walk_done),
    .roots_o  (roots)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q    <= 7'd1;
      running_q   <= 1'b0;
      out_valid_o <= 1'b0;
      root_count_o <= '0;
    end else begin
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      if (accept && (opcode_i == OP_RUN)) begin
        running_q <= 1'b1;
      end else if (walk_done) begin
        running_q    <= 1'b0;
        out_valid_o  <= 1'b1;
        root_count_o <= 7'(roots);
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> !accept) else $error("request accepted during run");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_done |=> out_valid_o) else $error("run result lost");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, root_count_o} <= {1'b0, 7'(n_eff)}))
    else $error("root count exceeds vertex count");
endmodule
`default_nettype wire

@@ hw/rtl/grcc_ram.sv @@
`default_nettype none
module grcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ hw/rtl/grcc_adj.sv @@
`default_nettype none
// Adjacency matrix: one memory row per vertex, with a valid bit per row so a
// clear takes effect at once. Setting an edge is a read-modify-write.
module grcc_adj #(
  parameter int unsigned MaxVertices = grcc_pkg::MaxVertices
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           clear_i,
  input  wire logic                           set_i,
  input  wire logic [$clog2(MaxVertices)-1:0] set_row_i,
  input  wire logic [$clog2(MaxVertices)-1:0] set_col_i,
  input  wire logic                           rd_i,
  input  wire logic [$clog2(MaxVertices)-1:0] rd_row_i,
  output logic [MaxVertices-1:0]              row_o,
  output logic                                busy_o
);
  import grcc_pkg::*;
  localparam int unsigned Aw = $clog2(MaxVertices);

  logic [MaxVertices-1:0] valid_q;
  logic                   rmw_q;
  logic [Aw-1:0]          rmw_row_q, rmw_col_q;
  logic                   rd_valid_q;
  logic [MaxVertices-1:0] rdata;
  logic [MaxVertices-1:0] row_eff;
  logic [MaxVertices-1:0] wdata;
  logic [Aw-1:0]          raddr;

  assign raddr   = set_i ? set_row_i : rd_row_i;
  assign row_eff = rd_valid_q ? rdata : '0;
  assign row_o   = row_eff;
  assign busy_o  = rmw_q;
  always_comb begin
    wdata = row_eff;
    wdata[rmw_col_q] = 1'b1;
  end

  grcc_ram #(.Width(MaxVertices), .Depth(MaxVertices)) u_ram (
    .clk_i   (clk_i),
    .we_i    (rmw_q),
    .waddr_i (rmw_row_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rmw_q      <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      rmw_q      <= set_i;
      rd_valid_q <= !clear_i && (set_i || rd_i) && valid_q[raddr];
      if (clear_i) begin
        valid_q <= '0;
      end else if (rmw_q) begin
        valid_q[rmw_row_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rmw_row_q <= set_row_i;
    rmw_col_q <= set_col_i;
  end
endmodule
`default_nettype wire

@@ hw/rtl/grcc_walk.sv @@
`default_nettype none
// Sequencer for both DFS passes. One shared unit scans an adjacency row for
// the lowest unmarked neighbor; the stack and finish order sit in RAMs.
module grcc_walk #(
  parameter int unsigned MaxVertices = grcc_pkg::MaxVertices
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [$clog2(MaxVertices):0]   n_i,
  output logic                                rd_o,
  output logic [$clog2(MaxVertices)-1:0]      rd_row_o,
  input  wire logic [MaxVertices-1:0]         row_i,
  output logic                                done_o,
  output logic [$clog2(MaxVertices):0]        roots_o
);
  import grcc_pkg::*;
  localparam int unsigned Aw = $clog2(MaxVertices);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010, // pass 1 outer: pick next unmarked i
    S_TOP   = 9'b000000100, // read stack top
    S_ROW   = 9'b000001000, // issue adjacency row read
    S_PICK  = 9'b000010000, // search row
    S_FORD  = 9'b000100000, // pass 2 read finish_order
    S_FWAIT = 9'b001000000,
    S_FTEST = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic               pass2_q;
  logic [MaxVertices-1:0] mark_q;
  logic [Aw:0]        top_q, fin_q, idx_q, roots_q;
  logic [Aw-1:0]      v_q;
  logic [MaxVertices-1:0] inuse;
  logic [MaxVertices-1:0] cand;
  logic               found;
  logic [Aw-1:0]      wpick;
  logic               stk_we, fin_we;
  logic [Aw-1:0]      stk_waddr, stk_raddr, fin_raddr;
  logic [Aw-1:0]      stk_wdata;
  logic [Aw-1:0]      stk_rdata, fin_rdata;

  always_comb begin
    for (int k = 0; k < MaxVertices; k++) begin
      inuse[k] = (k < n_i);
    end
  end
  assign cand = row_i & ~mark_q & inuse;

  // Lowest set bit of cand.
  always_comb begin
    found = 1'b0;
    wpick = '0;
    for (int k = MaxVertices - 1; k >= 0; k--) begin
      if (cand[k]) begin
        found = 1'b1;
        wpick = Aw'(k);
      end
    end
  end

  assign rd_o      = (state_q == S_ROW);
  assign rd_row_o  = stk_rdata;
  assign stk_raddr = top_q[Aw-1:0] - Aw'(1);
  // fin_q already points at the entry once S_FORD has stepped it down
  assign fin_raddr = fin_q[Aw-1:0];
  assign done_o    = (state_q == S_DONE);
  assign roots_o   = roots_q;

  grcc_ram #(.Width(Aw), .Depth(MaxVertices)) u_stack (
    .clk_i (clk_i), .we_i (stk_we), .waddr_i (stk_waddr), .wdata_i (stk_wdata),
    .raddr_i (stk_raddr), .rdata_o (stk_rdata)
  );
  grcc_ram #(.Width(Aw), .Depth(MaxVertices)) u_finish (
    .clk_i (clk_i), .we_i (fin_we), .waddr_i (fin_q[Aw-1:0]), .wdata_i (v_q),
    .raddr_i (fin_raddr), .rdata_o (fin_rdata)
  );

  always_comb begin
    state_d   = state_q;
    stk_we    = 1'b0;
    stk_waddr = top_q[Aw-1:0];
    stk_wdata = '0;
    fin_we    = 1'b0;
    case (state_q)
      S_SCAN: begin
        if (idx_q >= n_i) begin
          state_d = S_FORD;
        end else if (!mark_q[idx_q[Aw-1:0]]) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = idx_q[Aw-1:0];
          state_d   = S_TOP;
        end
      end
      S_TOP:  state_d = S_ROW;
      S_ROW:  state_d = S_PICK;
      S_PICK: begin
        if (found && (top_q < (Aw+1)'(MaxVertices))) begin
          stk_we    = 1'b1;
          stk_wdata = wpick;
          state_d   = S_TOP;
        end else begin
          fin_we  = !pass2_q && (fin_q < (Aw+1)'(MaxVertices));
          state_d = (top_q == (Aw+1)'(1)) ? (pass2_q ? S_FORD : S_SCAN) : S_TOP;
        end
      end
      S_FORD:  state_d = (fin_q == '0) ? S_DONE : S_FWAIT;
      S_FWAIT: state_d = S_FTEST;
      S_FTEST: begin
        if (!mark_q[fin_rdata]) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = fin_rdata;
          state_d   = S_TOP;
        end else begin
          state_d = S_FORD;
        end
      end
      S_DONE:  state_d = S_IDLE;
      S_IDLE:  if (start_i) state_d = (n_i == '0) ? S_DONE : S_SCAN;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass2_q <= 1'b0;
      mark_q  <= '0;
      top_q   <= '0;
      fin_q   <= '0;
      idx_q   <= '0;
      roots_q <= '0;
      v_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: if (start_i) begin
          pass2_q <= 1'b0;
          mark_q  <= '0;
          fin_q   <= '0;
          idx_q   <= '0;
          roots_q <= '0;
        end
        S_SCAN: begin
          if (idx_q < n_i) begin
            if (!mark_q[idx_q[Aw-1:0]]) begin
              mark_q[idx_q[Aw-1:0]] <= 1'b1;
              top_q <= (Aw+1)'(1);
            end
            idx_q <= idx_q + (Aw+1)'(1);
          end else begin
            pass2_q <= 1'b1;
            mark_q  <= '0;
          end
        end
        S_ROW: v_q <= stk_rdata;
        S_PICK: begin
          if (found && (top_q < (Aw+1)'(MaxVertices))) begin
            mark_q[wpick] <= 1'b1;
            top_q <= top_q + (Aw+1)'(1);
          end else begin
            top_q <= top_q - (Aw+1)'(1);
            if (fin_we) fin_q <= fin_q + (Aw+1)'(1);
          end
        end
        S_FORD: if (fin_q != '0) fin_q <= fin_q - (Aw+1)'(1);
        S_FTEST: if (!mark_q[fin_rdata]) begin
          mark_q[fin_rdata] <= 1'b1;
          top_q   <= (Aw+1)'(1);
          roots_q <= roots_q + (Aw+1)'(1);
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ dv/graph_root_cover_counter_tb.sv @@
`timescale 1ns / 1ps
module graph_root_cover_counter_tb;
  import grcc_pkg::*;

  localparam int unsigned NumVtx = 64;
  localparam int unsigned StallLimit = 200000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] opcode_i = OP_NONE;
  logic [5:0] from_vertex_i = '0;
  logic [5:0] to_vertex_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [6:0] root_count_o;
  logic       cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = 7'd1;

  graph_root_cover_counter u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .from_vertex_i,
    .to_vertex_i, .out_valid_o, .out_stall_i, .root_count_o, .cfg_we_i, .cfg_wdata_i
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // predictor state
  logic [NumVtx-1:0] adj_rows [NumVtx];
  logic [6:0]        vtx_count;
  logic [6:0]        root_counts_q [$];
  int unsigned       mismatches;
  int unsigned       results_seen;
  int unsigned       runs_sent;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       hold_off;
  int unsigned       quiet_cycles;

  function automatic int unsigned lowest_free(int unsigned v, int unsigned n,
                                              logic [NumVtx-1:0] marks);
    for (int unsigned w = 0; w < n; w++)
      if (!marks[w] && adj_rows[v][w]) return w;
    return n;
  endfunction

  function automatic logic [6:0] count_roots();
    int unsigned n;
    logic [NumVtx-1:0] seen;
    logic [NumVtx-1:0] reached;
    int unsigned order [NumVtx];
    int unsigned stk [NumVtx];
    int unsigned done_cnt;
    int unsigned top;
    int unsigned v;
    int unsigned w;
    int unsigned roots;
    n = (vtx_count > NumVtx) ? NumVtx : vtx_count;
    seen = '0;
    reached = '0;
    done_cnt = 0;
    roots = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (!seen[i]) begin
        seen[i] = 1'b1;
        top = 1;
        stk[0] = i;
        while (top > 0) begin
          v = stk[top-1];
          w = lowest_free(v, n, seen);
          if (w < n) begin
            seen[w] = 1'b1;
            stk[top] = w;
            top++;
          end else begin
            top--;
            order[done_cnt] = v;
            done_cnt++;
          end
        end
      end
    end
    while (done_cnt > 0) begin
      done_cnt--;
      v = order[done_cnt];
      if (!reached[v]) begin
        roots++;
        reached[v] = 1'b1;
        top = 1;
        stk[0] = v;
        while (top > 0) begin
          w = lowest_free(stk[top-1], n, reached);
          if (w < n) begin
            reached[w] = 1'b1;
            stk[top] = w;
            top++;
          end else begin
            top--;
          end
        end
      end
    end
    return roots[6:0];
  endfunction

  // exp: -1 means use predictor
  task automatic send_request(logic [1:0] op, logic [5:0] src, logic [5:0] dst, int exp);
    logic [6:0] pred;
    while (($urandom_range(99) < send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    from_vertex_i <= src;
    to_vertex_i   <= dst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (op)
      OP_ADD_EDGE: adj_rows[src][dst] = 1'b1;
      OP_CLEAR: for (int i = 0; i < NumVtx; i++) adj_rows[i] = '0;
      OP_RUN: begin
        pred = count_roots();
        if (exp >= 0) pred = exp[6:0];
        root_counts_q = {root_counts_q, pred};
        runs_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic drain_and_set(logic [6:0] cnt);
    in_valid_i <= 1'b0;
    while (root_counts_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cnt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vtx_count = cnt;
  endtask

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (root_counts_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d", root_count_o);
        end else begin
          if (root_count_o !== root_counts_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("root_count mismatch: exp %0d got %0d", root_counts_q[0],
                       root_count_o);
          end
          void'(root_counts_q.pop_front());
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("graph_root_cover_counter_tb: done, errors");
      $finish;
    end
  end

  typedef struct {
    logic [1:0] op;
    logic [5:0] src;
    logic [5:0] dst;
    int         exp;
  } stim_row_t;

  stim_row_t dir_rows [] = '{
    '{OP_RUN, 6'd0, 6'd0, 1},       // after reset: one isolated vertex
    '{OP_NONE, 6'd63, 6'd63, -1},   // unused opcode
    '{OP_ADD_EDGE, 6'd0, 6'd63, -1},
    '{OP_ADD_EDGE, 6'd63, 6'd0, -1},
    '{OP_ADD_EDGE, 6'd0, 6'd63, -1}, // repeat
    '{OP_ADD_EDGE, 6'd0, 6'd0, -1},  // self loop
    '{OP_RUN, 6'd0, 6'd0, 1},
    '{OP_CLEAR, 6'd0, 6'd0, -1},
    '{OP_RUN, 6'd0, 6'd0, 1}
  };

  function automatic logic [6:0] rand_count();
    case ($urandom_range(5))
      0: return 7'd0;
      1: return 7'd64;
      2: return 7'd127;
      3: return 7'd1;
      default: return 7'($urandom_range(12, 2));
    endcase
  endfunction

  initial begin
    int unsigned n;
    mismatches = 0;
    results_seen = 0;
    runs_sent = 0;
    hold_off = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    vtx_count = 7'd1;
    for (int i = 0; i < NumVtx; i++) adj_rows[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_request(dir_rows[i].op, dir_rows[i].src, dir_rows[i].dst,
                                       dir_rows[i].exp);
    drain_and_set(7'd0);
    send_request(OP_RUN, 6'd0, 6'd0, 0);     // zero vertices
    drain_and_set(7'd64);
    send_request(OP_RUN, 6'd0, 6'd0, 64);    // graph cleared: every vertex a root
    drain_and_set(7'd127);
    send_request(OP_RUN, 6'd0, 6'd0, 64);    // saturates

    // long receiver hold-off while requests wait at the stalled input
    hold_off = 400;
    for (int i = 0; i < 6; i++) send_request(OP_RUN, 6'd0, 6'd0, -1);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 77 : 0;
      recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 24 : 0;
      for (int blk = 0; blk < 14; blk++) begin
        drain_and_set(rand_count());
        n = (vtx_count == 0) ? 1 : (vtx_count > 64 ? 64 : vtx_count);
        if ($urandom_range(1)) send_request(OP_CLEAR, 6'($urandom), 6'($urandom), -1);
        for (int k = 0; k < 12; k++) begin
          if ($urandom_range(9) == 0)
            send_request(2'($urandom), 6'($urandom), 6'($urandom), -1);
          else
            send_request(OP_ADD_EDGE, 6'($urandom_range(n - 1)),
                         6'($urandom_range(n - 1)), -1);
          if ($urandom_range(5) == 0) send_request(OP_RUN, 6'($urandom), 6'($urandom), -1);
        end
        send_request(OP_RUN, 6'($urandom), 6'($urandom), -1);
      end
    end

    in_valid_i <= 1'b0;
    while (root_counts_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d run requests, %0d results checked, vertex counts 0..127",
             runs_sent, results_seen);
    if (mismatches == 0 && root_counts_q.size() == 0) begin
      $display("graph_root_cover_counter_tb: done, clean");
    end else begin
      $display("graph_root_cover_counter_tb: done, errors");
    end
    $finish;
  end
endmodule
